/* src/laplacian_edge_threshold_macros.svh */
// Assertion macros for the Laplacian edge threshold block.
// Included by the RTL files that carry concurrent checks; expects clk and rst in scope.
`ifndef LAPLACIAN_EDGE_THRESHOLD_MACROS_SVH
`define LAPLACIAN_EDGE_THRESHOLD_MACROS_SVH

// property must hold on every rising clock edge outside reset
`define LAPET_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define LAPET_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* src/lapet_pkg.sv */
// Shared types and constants for the Laplacian edge threshold block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lapet_pkg;

  localparam int MAX_LINE = 1024;
  localparam int MAX_ROWS = 1024;
  localparam int PIX_W    = 8;
  localparam int POS_W    = 10;
  localparam int DIM_W    = 11;
  localparam int LINE_AW  = $clog2(MAX_LINE);
  localparam int QD       = 4;
  localparam int QAW      = $clog2(QD);
  localparam int QLW      = $clog2(QD + 1);
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(5);

  // register index, taken from paddr[2]
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } pix_item_t;

  typedef struct packed {
    logic             edge_res;
    logic [POS_W-1:0] center_row;
    logic [POS_W-1:0] center_col;
    logic             frame_last;
  } res_item_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } dims_t;

  typedef struct packed {
    logic                 rd_en;
    logic [LINE_AW-1:0]   rd_addr;
    logic                 wr_en;
    logic [LINE_AW-1:0]   wr_addr;
    logic [2*PIX_W-1:0]   wr_data;
  } line_req_t;

endpackage

`default_nettype wire

/* src/lapet_cfg.sv */
// APB register file: frame width and height, with clamped copies for the datapath.
// Depends on lapet_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lapet_cfg
  import lapet_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output dims_t             dims
);

  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic             wr_hit;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    if (v < DIM_W'(3)) r = DIM_W'(3);
    else if (v > hi)   r = hi;
    else               r = v;
    return r;
  endfunction

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_RESET;
      frame_height <= DIM_RESET;
    end else if (wr_hit) begin
      case (paddr[2])
        REG_FRAME_WIDTH:  frame_width  <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH:  prdata = {{(APB_DW-DIM_W){1'b0}}, frame_width};
      REG_FRAME_HEIGHT: prdata = {{(APB_DW-DIM_W){1'b0}}, frame_height};
      default:          prdata = '0;
    endcase
  end

  assign dims.width  = clamp_dim(frame_width, DIM_W'(MAX_LINE));
  assign dims.height = clamp_dim(frame_height, DIM_W'(MAX_ROWS));

endmodule

`default_nettype wire

/* src/lapet_line_mem.sv */
// Line store memory: upper and middle rows packed per column, registered read.
// Forwards a write that lands on the edge of a read to the same column. Depends on lapet_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lapet_line_mem
  import lapet_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  line_req_t          req,
  output logic [2*PIX_W-1:0] rd_data
);

  logic [2*PIX_W-1:0] mem [MAX_LINE];
  logic [2*PIX_W-1:0] rd_q;
  logic [2*PIX_W-1:0] fwd_data;
  logic               fwd_hit;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q     <= mem[req.rd_addr];
      fwd_data <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (req.rd_en) begin
      fwd_hit <= req.wr_en && (req.wr_addr == req.rd_addr);
    end
  end

  assign rd_data = fwd_hit ? fwd_data : rd_q;

endmodule

`default_nettype wire

/* src/lapet_window.sv */
// 3x3 window columns and Laplacian threshold: 8*center against the sum of the neighbors.
// Depends on lapet_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lapet_window
  import lapet_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             shift_en,
  input  logic [PIX_W-1:0] top,
  input  logic [PIX_W-1:0] mid,
  input  logic [PIX_W-1:0] bot,
  output logic             edge_bit
);

  // col_a is the oldest stored column, col_b the newer; index 0 top, 2 bottom
  logic [PIX_W-1:0] col_a [3];
  logic [PIX_W-1:0] col_b [3];
  logic [DIM_W-1:0] pos_sum;
  logic [DIM_W-1:0] neg_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        col_a[i] <= '0;
        col_b[i] <= '0;
      end
    end else if (shift_en) begin
      for (int i = 0; i < 3; i++) begin
        col_a[i] <= col_b[i];
      end
      col_b[0] <= top;
      col_b[1] <= mid;
      col_b[2] <= bot;
    end
  end

  // window after this shift: col_a | col_b | {top, mid, bot}, center is col_b[1]
  assign pos_sum = {col_b[1], 3'b000};
  assign neg_sum = DIM_W'(col_a[0]) + DIM_W'(col_a[1]) + DIM_W'(col_a[2])
                 + DIM_W'(col_b[0]) + DIM_W'(col_b[2])
                 + DIM_W'(top) + DIM_W'(mid) + DIM_W'(bot);
  assign edge_bit = pos_sum > neg_sum;

endmodule

`default_nettype wire

/* src/lapet_out_queue.sv */
// Four-entry result queue between the datapath and the output channel.
// Depends on lapet_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lapet_out_queue
  import lapet_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  res_item_t      push_item,
  output logic           res_valid,
  input  logic           res_stall,
  output res_item_t      res_item,
  output logic [QLW-1:0] level
);

  res_item_t        slots [QD];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic             pop;

  assign res_valid = level != '0;
  assign res_item  = slots[rd_ptr];
  assign pop       = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QAW'(1);
      if (pop)  rd_ptr <= rd_ptr + QAW'(1);
      case ({push, pop})
        2'b10:   level <= level + QLW'(1);
        2'b01:   level <= level - QLW'(1);
        default: level <= level;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/laplacian_edge_threshold.sv */
// Top level of the streaming 3x3 Laplacian edge detector: counters, pipeline stage, wiring.
// Depends on lapet_pkg, lapet_cfg, lapet_line_mem, lapet_window, lapet_out_queue.
//
//   channel  direction  handshake               payload
//   pix      in         pix_valid / pix_stall   pix_item   (pixel, frame_start)
//   res      out        res_valid / res_stall   res_item   (edge_res, center_row/col, frame_last)
//   apb      in         psel/penable, pready=1  paddr, pwdata, prdata
//
// One pixel item per cycle while pix_stall is low; one line memory read and write-back per item.
// A result is registered in the s1 stage, then pushed into the result queue that drives res.
// Reset zeroes the counters and empties the queue, sets both sizes to 5; no memory sweep.
// Results wait in a four-entry queue; pix_stall rises when queued plus in-flight results reach 4.
`timescale 1ns / 1ps
`default_nettype none
`include "laplacian_edge_threshold_macros.svh"

module laplacian_edge_threshold
  import lapet_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              pix_valid,
  output logic              pix_stall,
  input  pix_item_t         pix_item,
  output logic              res_valid,
  input  logic              res_stall,
  output res_item_t         res_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  dims_t              dims;
  line_req_t          line_req;
  logic [2*PIX_W-1:0] line_rd;

  logic [POS_W-1:0]   col_count;
  logic [POS_W-1:0]   row_count;
  logic [POS_W-1:0]   col_next;
  logic [POS_W-1:0]   row_next;
  logic [POS_W-1:0]   c_cur;
  logic [POS_W-1:0]   r_cur;
  logic [DIM_W-1:0]   col_inc;
  logic [DIM_W-1:0]   row_inc;
  logic               pix_accept;
  logic               interior;

  logic               s1_valid;
  logic               s1_prod;
  logic [PIX_W-1:0]   s1_px;
  logic [LINE_AW-1:0] s1_addr;
  logic [POS_W-1:0]   s1_row;
  logic [POS_W-1:0]   s1_col;
  logic               s1_last;

  logic               edge_bit;
  res_item_t          push_item;
  logic [QLW-1:0]     q_level;

  lapet_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .dims
  );

  assign pix_stall  = ({1'b0, q_level} + (QLW+1)'(s1_prod)) >= (QLW+1)'(QD);
  assign pix_accept = pix_valid && !pix_stall;

  assign c_cur   = pix_item.frame_start ? '0 : col_count;
  assign r_cur   = pix_item.frame_start ? '0 : row_count;
  assign col_inc = {1'b0, c_cur} + DIM_W'(1);
  assign row_inc = {1'b0, r_cur} + DIM_W'(1);
  assign interior = (r_cur >= POS_W'(2)) && (c_cur >= POS_W'(2));

  always_comb begin
    if (col_inc >= dims.width) begin
      col_next = '0;
      row_next = (row_inc >= dims.height) ? '0 : row_inc[POS_W-1:0];
    end else begin
      col_next = col_inc[POS_W-1:0];
      row_next = r_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      s1_valid  <= 1'b0;
      s1_prod   <= 1'b0;
    end else begin
      s1_valid <= pix_accept;
      s1_prod  <= pix_accept && interior;
      if (pix_accept) begin
        col_count <= col_next;
        row_count <= row_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_accept) begin
      s1_px   <= pix_item.pixel;
      s1_addr <= c_cur[LINE_AW-1:0];
      s1_row  <= r_cur - POS_W'(1);
      s1_col  <= c_cur - POS_W'(1);
      s1_last <= (row_inc >= dims.height) && (col_inc >= dims.width);
    end
  end

  // read at accept, write back {old middle -> upper, new pixel -> middle} in the next cycle from s1
  assign line_req.rd_en   = pix_accept;
  assign line_req.rd_addr = c_cur[LINE_AW-1:0];
  assign line_req.wr_en   = s1_valid;
  assign line_req.wr_addr = s1_addr;
  assign line_req.wr_data = {line_rd[PIX_W-1:0], s1_px};

  lapet_line_mem u_line_mem (
    .clk, .rst, .req(line_req), .rd_data(line_rd)
  );

  lapet_window u_window (
    .clk, .rst,
    .shift_en (s1_valid),
    .top      (line_rd[2*PIX_W-1:PIX_W]),
    .mid      (line_rd[PIX_W-1:0]),
    .bot      (s1_px),
    .edge_bit (edge_bit)
  );

  assign push_item.edge_res   = edge_bit;
  assign push_item.center_row = s1_row;
  assign push_item.center_col = s1_col;
  assign push_item.frame_last = s1_last;

  lapet_out_queue u_out_queue (
    .clk, .rst,
    .push      (s1_prod),
    .push_item (push_item),
    .res_valid,
    .res_stall,
    .res_item,
    .level     (q_level)
  );

  `LAPET_NEVER(a_queue_overflow, s1_prod && (q_level == QLW'(QD)) && (res_stall || !res_valid), "result queue overflow")
  `LAPET_CHECK(a_interior_only, s1_prod |-> (s1_valid && s1_row != '0 && s1_col != '0), "border result")
  `LAPET_CHECK(a_col_step, (pix_accept && !pix_item.frame_start) |=> (col_count == '0 || col_count == $past(col_count) + POS_W'(1)), "column counter skipped")

endmodule

`default_nettype wire

/* sim/laplacian_edge_threshold_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for laplacian_edge_threshold: tracks APB register writes and the pixel stream,
// predicts every interior edge result and compares it with the res channel.
// Depends on lapet_pkg.
module laplacian_edge_threshold_checker
  import lapet_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              pix_valid,
  input  logic              pix_stall,
  input  pix_item_t         pix_item,
  input  logic              res_valid,
  input  logic              res_stall,
  input  res_item_t         res_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output int                mismatch_count,
  output int                edges_outstanding
);

  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic [PIX_W-1:0] upper_line [MAX_LINE];
  logic [PIX_W-1:0] middle_line [MAX_LINE];
  logic [PIX_W-1:0] win [9];
  int unsigned      col_pos;
  int unsigned      row_pos;
  res_item_t        pending_edges [$];
  int               fails = 0;

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic convolve_pixel(pix_item_t it);
    int unsigned      w;
    int unsigned      h;
    int unsigned      c;
    int unsigned      r;
    int               sum;
    int               k;
    logic [PIX_W-1:0] top_px;
    logic [PIX_W-1:0] mid_px;
    res_item_t        res;
    w = clamp_dim(width_reg, MAX_LINE);
    h = clamp_dim(height_reg, MAX_ROWS);
    if (it.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    r = row_pos;
    if (c >= MAX_LINE) c = 0;
    top_px = upper_line[c];
    mid_px = middle_line[c];
    upper_line[c] = mid_px;
    middle_line[c] = it.pixel;
    for (k = 0; k < 3; k++) begin
      win[3*k]   = win[3*k+1];
      win[3*k+1] = win[3*k+2];
    end
    win[2] = top_px;
    win[5] = mid_px;
    win[8] = it.pixel;
    if (r >= 2 && c >= 2) begin
      sum = 8 * int'(win[4]);
      for (k = 0; k < 9; k++) begin
        if (k != 4) sum -= int'(win[k]);
      end
      res.edge_res   = (sum > 0);
      res.center_row = POS_W'(r - 1);
      res.center_col = POS_W'(c - 1);
      res.frame_last = (r + 1 >= h) && (c + 1 >= w);
      pending_edges.push_back(res);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  task automatic compare_edge(res_item_t got);
    res_item_t want;
    if (pending_edges.size() == 0) begin
      fails++;
      if (fails <= 10)
        $display("%0t: unexpected result edge=%0d row=%0d col=%0d last=%0d", $realtime,
                 got.edge_res, got.center_row, got.center_col, got.frame_last);
      return;
    end
    want = pending_edges.pop_front();
    if (got.edge_res !== want.edge_res || got.center_row !== want.center_row ||
        got.center_col !== want.center_col || got.frame_last !== want.frame_last) begin
      fails++;
      if (fails <= 10)
        $display("%0t: mismatch exp edge=%0d row=%0d col=%0d last=%0d, got edge=%0d row=%0d col=%0d last=%0d",
                 $realtime, want.edge_res, want.center_row, want.center_col, want.frame_last,
                 got.edge_res, got.center_row, got.center_col, got.frame_last);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = DIM_RESET;
      height_reg = DIM_RESET;
      for (int i = 0; i < MAX_LINE; i++) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      for (int i = 0; i < 9; i++) win[i] = '0;
      col_pos = 0;
      row_pos = 0;
      pending_edges.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_FRAME_WIDTH) width_reg = pwdata[DIM_W-1:0];
        else height_reg = pwdata[DIM_W-1:0];
      end
      if (pix_valid && !pix_stall) convolve_pixel(pix_item);
      if (res_valid && !res_stall) compare_edge(res_item);
    end
    mismatch_count    <= fails;
    edges_outstanding <= pending_edges.size();
  end

endmodule

/* sim/laplacian_edge_threshold_tb.sv */
`timescale 1ns / 1ps
// Top of the laplacian_edge_threshold testbench: clock, reset, APB setup and pixel stimulus.
// Depends on lapet_pkg, laplacian_edge_threshold and laplacian_edge_threshold_checker.
module laplacian_edge_threshold_tb;
  import lapet_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RUN_LIMIT    = 1_000_000;
  localparam int RANDOM_ITEMS = 900;

  typedef enum int {TEX_UNIFORM, TEX_FLAT, TEX_BINARY} texture_e;
  typedef enum int {FR_NORMAL, FR_NO_START, FR_TRUNCATED, FR_NOISY} frame_style_e;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              pix_valid = 1'b0;
  logic              pix_stall;
  pix_item_t         pix_item  = '0;
  logic              res_valid;
  logic              res_stall = 1'b0;
  res_item_t         res_item;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [APB_AW-1:0] paddr     = '0;
  logic [APB_DW-1:0] pwdata    = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int mismatch_count;
  int edges_outstanding;
  int gap_pct     = 0;
  int stall_pct   = 0;
  int stall_left  = 0;
  int cycle_count = 0;
  int items_sent  = 0;

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  laplacian_edge_threshold u_top (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_item  (pix_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  laplacian_edge_threshold_checker u_check (
    .clk               (clk),
    .rst               (rst),
    .pix_valid         (pix_valid),
    .pix_stall         (pix_stall),
    .pix_item          (pix_item),
    .res_valid         (res_valid),
    .res_stall         (res_stall),
    .res_item          (res_item),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .pready            (pready),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .mismatch_count    (mismatch_count),
    .edges_outstanding (edges_outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result-side backpressure in bursts of random length
  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (stall_left > 0 && stall_pct != 0) begin
      stall_left <= stall_left - 1;
      res_stall  <= 1'b1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 16);
      res_stall  <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  function automatic logic [PIX_W-1:0] texture_pixel(texture_e tex, logic [PIX_W-1:0] base);
    int v;
    case (tex)
      TEX_FLAT: begin
        v = int'(base) + int'($urandom_range(0, 6)) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return PIX_W'(v);
      end
      TEX_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic send_pixel(logic [PIX_W-1:0] px, logic fs);
    int        gap;
    pix_item_t it;
    gap = 0;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 17);
    repeat (gap) begin
      @(negedge clk);
      pix_valid <= 1'b0;
    end
    it.pixel       = px;
    it.frame_start = fs;
    @(negedge clk);
    pix_valid <= 1'b1;
    pix_item  <= it;
    do @(posedge clk); while (pix_stall);
    items_sent++;
  endtask

  task automatic send_run(int unsigned count, logic first_start, int noise_pct, texture_e tex);
    logic [PIX_W-1:0] base;
    logic             fs;
    base = PIX_W'($urandom);
    for (int unsigned n = 0; n < count; n++) begin
      if (n == 0) fs = first_start;
      else fs = (noise_pct != 0) && ($urandom_range(0, 99) < noise_pct);
      send_pixel(texture_pixel(tex, base), fs);
    end
  endtask

  task automatic write_reg(logic idx, logic [DIM_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {21'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // drain all results, then give the pipeline time to empty
  task automatic settle();
    @(negedge clk);
    pix_valid <= 1'b0;
    while (edges_outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    logic [DIM_W-1:0] cur_w;
    logic [DIM_W-1:0] cur_h;
    logic [DIM_W-1:0] prev_h;
    int unsigned      ew;
    int unsigned      eh;
    int unsigned      pick;
    frame_style_e     style;
    texture_e         tex;

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // widest line the random frames use, height clamped up: fills both line stores over it
    gap_pct   = 3;
    stall_pct = 3;
    write_reg(REG_FRAME_WIDTH, 11'd48);
    write_reg(REG_FRAME_HEIGHT, 11'd2);
    send_run(48 * 3, 1'b1, 0, TEX_UNIFORM);

    // smallest frames: strongest positive response, flat (zero sum), strongest negative
    gap_pct   = 0;
    stall_pct = 0;
    settle();
    write_reg(REG_FRAME_WIDTH, 11'd3);
    write_reg(REG_FRAME_HEIGHT, 11'd3);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 8'hFF : 8'h00, i == 0);
    for (int i = 0; i < 9; i++) send_pixel(8'd77, 1'b0);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 8'h00 : 8'hFF, i == 0);

    // tall frame, narrow width clamped up, left unfinished
    gap_pct   = 3;
    stall_pct = 3;
    settle();
    write_reg(REG_FRAME_WIDTH, 11'd1);
    write_reg(REG_FRAME_HEIGHT, 11'd2047);
    cur_w = 11'd1;
    cur_h = 11'd2047;
    send_run(3 * 100, 1'b1, 0, TEX_UNIFORM);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0: gap_pct = 0;
        1: gap_pct = 3;
        2: gap_pct = 15;
        default: gap_pct = 40;
      endcase
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 3;
        2: stall_pct = 15;
        default: stall_pct = 40;
      endcase
      settle();
      prev_h = cur_h;
      if (pick < 75) begin
        cur_w = $urandom_range(3, 10);
        cur_h = $urandom_range(3, 8);
      end else if (pick < 85) begin
        cur_w = $urandom_range(0, 2);
        cur_h = $urandom_range(0, 4);
      end else if (pick < 93) begin
        cur_w = $urandom_range(11, 48);
        cur_h = $urandom_range(3, 4);
      end else begin
        cur_w = $urandom_range(3, 10);
        cur_h = $urandom_range(0, 2);
      end
      write_reg(REG_FRAME_WIDTH, cur_w);
      if (items_sent == 0 || $urandom_range(0, 4) != 0) write_reg(REG_FRAME_HEIGHT, cur_h);
      else cur_h = prev_h;
      ew = (cur_w < 3) ? 3 : cur_w;
      eh = (cur_h < 3) ? 3 : cur_h;
      repeat ($urandom_range(1, 3)) begin
        style = frame_style_e'($urandom_range(0, 9) < 6 ? FR_NORMAL : $urandom_range(1, 3));
        tex   = texture_e'($urandom_range(0, 2));
        case (style)
          FR_NORMAL:    send_run(ew * eh, 1'b1, 0, tex);
          FR_NO_START:  send_run(ew * eh, 1'b0, 0, tex);
          FR_TRUNCATED: send_run($urandom_range(1, ew * eh - 1), 1'b1, 0, tex);
          default:      send_run(ew * eh, 1'b1, 5, tex);
        endcase
      end
      // sometimes leave the frame half done so the next size change lands mid-frame
      if ($urandom_range(0, 5) == 0)
        send_run($urandom_range(1, ew * eh - 1), $urandom_range(0, 1), 0, TEX_UNIFORM);
    end

    gap_pct   = 0;
    stall_pct = 0;
    settle();
    write_reg(REG_FRAME_WIDTH, 11'd6);
    write_reg(REG_FRAME_HEIGHT, 11'd5);
    repeat (5) send_run(30, 1'b1, 0, TEX_UNIFORM);
    send_run(30, 1'b0, 0, TEX_FLAT);
    settle();

    if (mismatch_count == 0 && edges_outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
